@@ design/blowfish_block_cipher_assert.svh @@
// Assertion macros used by the checker file of the cipher engine.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef BLOWFISH_BLOCK_CIPHER_ASSERT_SVH
`define BLOWFISH_BLOCK_CIPHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bf_pkg.sv @@
`default_nettype none

package bf_pkg;

    // Table geometry
    localparam int NUM_SUBKEYS   = 18;
    localparam int KEY_IDX_W     = 5;
    localparam int NUM_BOXES     = 4;
    localparam int BOX_DEPTH     = 256;
    localparam int BOX_IDX_W     = 8;
    localparam int WORD_W        = 32;
    localparam int BLOCK_W       = 64;
    localparam int TABLE_IDX_W   = 10;

    // Key sequence positions: last round consumes key 16, output whitening key 17
    localparam logic [KEY_IDX_W-1:0] FINAL_KEY      = 5'd17;
    localparam logic [KEY_IDX_W-1:0] LAST_ROUND_CNT = 5'd16;

    // Request packing on the slave side
    localparam int S_TDATA_W     = 112;
    localparam int M_TDATA_W     = 64;

    typedef enum logic [1:0] {
        ACT_ENCRYPT   = 2'd0,
        ACT_DECRYPT   = 2'd1,
        ACT_LOAD_KEY  = 2'd2,
        ACT_LOAD_SBOX = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ design/blowfish_block_cipher.sv @@
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: action, block_in, table_index,
//                                                   table_word; tlast: last_in
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: block_out; tlast: last_out
//
// A cipher request runs from acceptance to a valid result in these steps: the first subkey
// is read at the accepting edge, then one whitening step, 16 rounds at one round per
// cycle (the S-box banks register their words from the address), and one output step.
// A load request writes its table word at the edge that accepts it.
// Reset (aresetn low at a clock edge) clears control only; tables are unknown.
// A result held by m_axis_tready low stalls the next cipher request in its last step;
// no load request is taken meanwhile either, as s_axis_tready is low until idle.
`default_nettype none

module blowfish_block_cipher
    import bf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] action, [65:2] block_in, [75:66] table_index, [107:76] table_word,
    // [111:108] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [63:0] block_out
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tlast
);

    // Request fields
    action_t                  in_action;
    logic [BLOCK_W-1:0]       in_block;
    logic [TABLE_IDX_W-1:0]   in_index;
    logic [WORD_W-1:0]        in_word;
    logic                     in_acc;

    // Tables
    logic [WORD_W-1:0]        sk_mem   [NUM_SUBKEYS];
    logic [WORD_W-1:0]        sbox_mem [NUM_BOXES][BOX_DEPTH];

    // Control and datapath registers
    state_t                   state_reg, state_next;
    logic [KEY_IDX_W-1:0]     cnt_reg, cnt_next;
    logic                     dec_reg, dec_next;
    logic                     last_reg, last_next;
    logic [WORD_W-1:0]        l_reg, l_next;
    logic [WORD_W-1:0]        r_reg, r_next;
    logic [WORD_W-1:0]        sk_q_reg;
    logic [WORD_W-1:0]        sb_q_reg [NUM_BOXES];
    logic                     out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]       out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    // Memory access controls
    logic                     sk_rd_en;
    logic [KEY_IDX_W-1:0]     sk_rd_addr;
    logic                     sb_rd_en;
    logic [BOX_IDX_W-1:0]     sb_addr [NUM_BOXES];
    logic                     sk_wr_en;
    logic                     sb_wr_en;
    logic [WORD_W-1:0]        f_val;
    logic [WORD_W-1:0]        round_r;

    // Key index for step i of the schedule, reversed when deciphering
    function automatic logic [KEY_IDX_W-1:0] key_sel(input logic dec,
                                                     input logic [KEY_IDX_W-1:0] i);
        key_sel = dec ? (FINAL_KEY - i) : i;
    endfunction

    assign in_action = action_t'(s_axis_tdata[1:0]);
    assign in_block  = s_axis_tdata[65:2];
    assign in_index  = s_axis_tdata[75:66];
    assign in_word   = s_axis_tdata[107:76];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign sk_wr_en = in_acc && (in_action == ACT_LOAD_KEY)
                      && (in_index < TABLE_IDX_W'(NUM_SUBKEYS));
    assign sb_wr_en = in_acc && (in_action == ACT_LOAD_SBOX);

    // Round function over the registered S-box words
    assign f_val   = ((sb_q_reg[0] + sb_q_reg[1]) ^ sb_q_reg[2]) + sb_q_reg[3];
    assign round_r = r_reg ^ f_val;

    // Write loads, read subkeys when the sequencer asks
    always_ff @(posedge aclk) begin
        if (sk_wr_en) begin
            sk_mem[in_index[KEY_IDX_W-1:0]] <= in_word;
        end
        if (sk_rd_en) begin
            sk_q_reg <= sk_mem[sk_rd_addr];
        end
    end

    // Write loads, read all four S-box banks together
    always_ff @(posedge aclk) begin
        if (sb_wr_en) begin
            sbox_mem[in_index[TABLE_IDX_W-1:BOX_IDX_W]][in_index[BOX_IDX_W-1:0]] <= in_word;
        end
        if (sb_rd_en) begin
            for (int b = 0; b < NUM_BOXES; b++) begin
                sb_q_reg[b] <= sbox_mem[b][sb_addr[b]];
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        dec_reg      <= dec_next;
        last_reg     <= last_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // Sequence the rounds
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dec_next       = dec_reg;
        last_next      = last_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        sk_rd_en       = 1'b0;
        sk_rd_addr     = key_sel(dec_reg, cnt_reg + 5'd1);
        sb_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_action inside {ACT_ENCRYPT, ACT_DECRYPT})) begin
                    dec_next   = (in_action == ACT_DECRYPT);
                    last_next  = s_axis_tlast;
                    l_next     = in_block[BLOCK_W-1:WORD_W];
                    r_next     = in_block[WORD_W-1:0];
                    cnt_next   = '0;
                    sk_rd_en   = 1'b1;
                    sk_rd_addr = key_sel(in_action == ACT_DECRYPT, '0);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Whiten the left half and fetch its S-box words
                l_next     = l_reg ^ sk_q_reg;
                sb_rd_en   = 1'b1;
                sk_rd_en   = 1'b1;
                cnt_next   = cnt_reg + 5'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                sk_rd_en = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_ROUND_CNT) begin
                    // Last round: no swap, fold in the right whitening key
                    r_next     = round_r ^ sk_q_reg;
                    state_next = ST_FINISH;
                end else begin
                    l_next   = round_r ^ sk_q_reg;
                    r_next   = l_reg;
                    sb_rd_en = 1'b1;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready) begin
                    out_data_next  = {l_reg ^ sk_q_reg, r_reg};
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // S-box addresses come from the bytes of the next left half
    always_comb begin
        for (int b = 0; b < NUM_BOXES; b++) begin
            sb_addr[b] = l_next[WORD_W-1-BOX_IDX_W*b -: BOX_IDX_W];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ design/bf_checker.sv @@
`default_nettype none
`include "blowfish_block_cipher_assert.svh"

module bf_checker
    import bf_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tlast
);

    logic s_acc;
    logic s_is_load;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign s_is_load = (s_axis_tdata[1:0] == ACT_LOAD_KEY)
                       || (s_axis_tdata[1:0] == ACT_LOAD_SBOX);

    // A stalled result holds
    `BF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // A cipher request occupies the engine
    `BF_ASSERT_NEXT(a_busy_after_cipher, s_acc && !s_is_load, !s_axis_tready, "engine took a request during a cipher run")

    // A new result only ends a cipher run
    `BF_ASSERT_NOW(a_result_from_run, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without a cipher run")

    // A load request never produces a result
    `BF_ASSERT_NEXT(a_load_silent, s_acc && s_is_load && !m_axis_tvalid, !m_axis_tvalid, "load request produced a result")

endmodule

bind blowfish_block_cipher bf_checker u_bf_checker (.*);

`default_nettype wire

@@ tb/sv/blowfish_block_cipher_tb.sv @@
`timescale 1ns / 100ps

module blowfish_block_cipher_tb;
    import bf_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 860;
    localparam int SEGMENTS     = 8;

    // One expected cipher result
    typedef struct {
        logic [BLOCK_W-1:0] block;
        logic               last;
    } cipher_result_t;

    // Own copy of the key tables; predicts the result of every accepted cipher request
    class cipher_scoreboard;
        logic [WORD_W-1:0] key_words[NUM_SUBKEYS];
        logic [WORD_W-1:0] sbox_table[NUM_BOXES*BOX_DEPTH];
        cipher_result_t    pending_blocks[$];
        int                failures;
        int                results_checked;

        function new();
            foreach (key_words[i]) key_words[i] = '0;
            foreach (sbox_table[i]) sbox_table[i] = '0;
            failures = 0;
            results_checked = 0;
        endfunction

        function logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] x);
            logic [WORD_W-1:0] s0, s1, s2, s3;
            s0 = sbox_table[{2'd0, x[31:24]}];
            s1 = sbox_table[{2'd1, x[23:16]}];
            s2 = sbox_table[{2'd2, x[15:8]}];
            s3 = sbox_table[{2'd3, x[7:0]}];
            return ((s0 + s1) ^ s2) + s3;
        endfunction

        function logic [BLOCK_W-1:0] run_network(logic [BLOCK_W-1:0] blk, bit reverse);
            logic [WORD_W-1:0] lh, rh, swap;
            int                k;
            lh = blk[63:32];
            rh = blk[31:0];
            for (int n = 0; n < 16; n++) begin
                k = reverse ? (17 - n) : n;
                lh ^= key_words[k];
                rh ^= mix_word(lh);
                // no swap after the last round
                if (n != 15) begin
                    swap = lh;
                    lh   = rh;
                    rh   = swap;
                end
            end
            if (reverse) begin
                rh ^= key_words[1];
                lh ^= key_words[0];
            end else begin
                rh ^= key_words[16];
                lh ^= key_words[17];
            end
            return {lh, rh};
        endfunction

        // Apply an accepted request: update the tables or queue the expected block
        function void note_request(action_t act, logic [BLOCK_W-1:0] blk,
                                   logic [TABLE_IDX_W-1:0] idx, logic [WORD_W-1:0] word,
                                   logic last);
            cipher_result_t res;
            case (act)
                ACT_ENCRYPT, ACT_DECRYPT: begin
                    res.block = run_network(blk, act == ACT_DECRYPT);
                    res.last  = last;
                    pending_blocks.push_back(res);
                end
                ACT_LOAD_KEY: begin
                    // indexes beyond the key array are dropped
                    if (idx < NUM_SUBKEYS) key_words[idx] = word;
                end
                default: begin
                    sbox_table[idx] = word;
                end
            endcase
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic [BLOCK_W-1:0] blk, logic last);
            cipher_result_t res;
            if (pending_blocks.size() == 0) begin
                $error("unexpected result: block_out %h last_out %b", blk, last);
                failures++;
                return;
            end
            res = pending_blocks.pop_front();
            results_checked++;
            if (blk !== res.block) begin
                $error("block_out mismatch: expected %h, actual %h", res.block, blk);
                failures++;
            end
            if (last !== res.last) begin
                $error("last_out mismatch: expected %b, actual %b", res.last, last);
                failures++;
            end
        endfunction

        function int pending();
            return pending_blocks.size();
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    cipher_scoreboard board = new();
    int idle_pct      = 0;
    int stall_pct     = 0;
    int requests_sent = 0;
    int quiet_cycles  = 0;

    blowfish_block_cipher uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [1:0] action, [65:2] block_in, [75:66] table_index, [107:76] table_word,
        // [111:108] zero
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [63:0] block_out
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Sample both handshakes; end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_request(action_t'(s_axis_tdata[1:0]), s_axis_tdata[65:2],
                                   s_axis_tdata[75:66], s_axis_tdata[107:76],
                                   s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tlast);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [BLOCK_W-1:0] pick_block();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Present one request from a falling edge and hold it until accepted
    task automatic send_request(input action_t act, input logic [BLOCK_W-1:0] blk,
                                input logic [TABLE_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] word, input logic last);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, word, idx, blk, act};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_cipher(input action_t act, input logic last);
        send_request(act, pick_block(), TABLE_IDX_W'($urandom()), $urandom(), last);
    endtask

    task automatic send_load(input action_t act, input logic [TABLE_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] word);
        send_request(act, {$urandom(), $urandom()}, idx, word, 1'($urandom()));
    endtask

    initial begin
        int      kind;
        int      len;
        action_t act;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill every table entry before any cipher request reads one
        for (int i = 0; i < NUM_SUBKEYS; i++) begin
            send_load(ACT_LOAD_KEY, TABLE_IDX_W'(i),
                      (i == 0) ? 32'h0 : (i == 17) ? 32'hffff_ffff : $urandom());
        end
        for (int i = 0; i < NUM_BOXES*BOX_DEPTH; i++) begin
            send_load(ACT_LOAD_SBOX, TABLE_IDX_W'(i), pick_word());
        end

        // Directed: extreme blocks, both directions, ignored fields, table edges
        send_request(ACT_ENCRYPT, '0, '0, '0, 1'b0);
        send_request(ACT_ENCRYPT, '1, '1, '1, 1'b1);
        send_request(ACT_DECRYPT, '0, '1, '0, 1'b1);
        send_request(ACT_DECRYPT, '1, '0, '1, 1'b0);
        send_request(ACT_ENCRYPT, 64'h0123_4567_89ab_cdef, 10'd1023, 32'hffff_ffff, 1'b1);
        send_request(ACT_LOAD_KEY, '1, 10'd17, 32'hffff_ffff, 1'b1);
        send_request(ACT_LOAD_KEY, '0, 10'd0, 32'h0, 1'b0);
        // out-of-range key indexes change nothing
        send_request(ACT_LOAD_KEY, '1, 10'd18, 32'hffff_ffff, 1'b1);
        send_request(ACT_LOAD_KEY, '0, 10'd1023, 32'h1234_5678, 1'b0);
        send_request(ACT_LOAD_SBOX, '1, 10'd0, 32'hffff_ffff, 1'b1);
        send_request(ACT_LOAD_SBOX, '0, 10'd1023, 32'h0, 1'b0);
        send_request(ACT_LOAD_SBOX, '0, 10'd255, 32'hffff_ffff, 1'b0);
        send_request(ACT_LOAD_SBOX, '0, 10'd768, 32'ha5a5_a5a5, 1'b0);
        send_request(ACT_ENCRYPT, '0, '0, '0, 1'b1);
        send_request(ACT_DECRYPT, '1, '0, '0, 1'b1);
        send_request(ACT_ENCRYPT, 64'hffff_ffff_0000_0000, '0, '0, 1'b0);
        send_request(ACT_DECRYPT, 64'h0000_0000_ffff_ffff, '0, '0, 1'b1);

        // Random traffic in segments, cycling through the pressure patterns
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            len = requests_sent + RANDOM_ITEMS / SEGMENTS;
            while (requests_sent < len) begin
                kind = $urandom_range(9);
                if (kind <= 3) begin
                    // single block
                    act = $urandom_range(1) ? ACT_DECRYPT : ACT_ENCRYPT;
                    send_cipher(act, 1'($urandom()));
                end else if (kind == 4) begin
                    // message of several blocks, marked last on the final one
                    act = $urandom_range(1) ? ACT_DECRYPT : ACT_ENCRYPT;
                    len += 0;
                    for (int b = 0, n = $urandom_range(2, 6); b < n; b++) begin
                        send_cipher(act, b == n - 1);
                    end
                end else if (kind <= 7) begin
                    send_load(ACT_LOAD_SBOX, TABLE_IDX_W'($urandom()), pick_word());
                end else if (kind == 8) begin
                    if ($urandom_range(4) == 0) begin
                        send_load(ACT_LOAD_KEY, TABLE_IDX_W'($urandom_range(1023, 18)),
                                  pick_word());
                    end else begin
                        send_load(ACT_LOAD_KEY, TABLE_IDX_W'($urandom_range(17)),
                                  pick_word());
                    end
                end else begin
                    // fresh key schedule, then a short message under it
                    for (int i = 0; i < NUM_SUBKEYS; i++) begin
                        send_load(ACT_LOAD_KEY, TABLE_IDX_W'(i), pick_word());
                    end
                    for (int b = 0; b < 3; b++) begin
                        send_cipher($urandom_range(1) ? ACT_DECRYPT : ACT_ENCRYPT, b == 2);
                    end
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the results, then let the pipeline settle
        stall_pct = 0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d requests and checked %0d cipher results", requests_sent,
                 board.results_checked);
        $display("Covered full table loads, rekeying and four handshake pressure patterns");
        if (board.failures == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
